// ===== design/iaop_pkg.sv =====
`default_nettype none

package iaop_pkg;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_IDIV = 3'd3,
    CMD_MOD  = 3'd4,
    CMD_ABS  = 3'd5,
    CMD_NEG  = 3'd6,
    CMD_PASS = 3'd7
  } cmd_t;

  typedef struct packed {
    logic        [2:0]  cmd;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [31:0] int_value;
    logic        [63:0] real_bits;
    logic               is_real;
    logic               div_zero;
  } out_t;

  // classified item as held in the queue; operands sign-extended to 64 bits
  typedef struct packed {
    cmd_t        cmd;
    logic [63:0] a;
    logic [63:0] b;
    logic        dz;
  } op_t;

endpackage

`default_nettype wire

// ===== design/iaop_front.sv =====
`default_nettype none

module iaop_front
  import iaop_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  input  wire logic q_full,
  output logic      q_push,
  output op_t       q_op
);

  logic signed [DATA_WIDTH-1:0] aw;
  logic signed [DATA_WIDTH-1:0] bw;
  logic signed [63:0]           ax;
  logic signed [63:0]           bx;
  logic signed [63:0]           a64;
  logic signed [63:0]           b64;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    a64 = in_data.operand_a;
    b64 = in_data.operand_b;
    aw  = a64[DATA_WIDTH-1:0];
    bw  = b64[DATA_WIDTH-1:0];
    ax  = aw;
    bx  = bw;
    q_op.cmd = cmd_t'(in_data.cmd);
    q_op.a   = ax;
    q_op.b   = bx;
    q_op.dz  = (q_op.cmd inside {CMD_IDIV, CMD_MOD}) && (bw == '0);
  end

endmodule

`default_nettype wire

// ===== design/iaop_queue.sv =====
`default_nettype none

module iaop_queue
  import iaop_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire op_t  push_op,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output op_t       head_op
);

  op_t        ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_op    = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(pop && head_valid)) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && pop && head_valid) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop && head_valid) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_op;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !push)
    else $error("transfer into full queue");
`endif

endmodule

`default_nettype wire

// ===== design/iaop_back.sv =====
`default_nettype none

module iaop_back
  import iaop_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire op_t  q_op,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam int W   = DATA_WIDTH;
  localparam int WW  = 2 * DATA_WIDTH;
  localparam int H   = (DATA_WIDTH + 1) / 2;
  localparam int L   = DATA_WIDTH - H;
  localparam int LZW = $clog2(WW);
  localparam int XW  = WW + 55;

  typedef struct packed {
    cmd_t         cmd;
    logic         dz;
    logic         sa;
    logic         sb;
    logic [W-1:0] a;
    logic [W-1:0] ma;
    logic [W-1:0] mb;
    logic [W-1:0] dv;
    logic [W-1:0] rem;
    logic [W-1:0] q;
  } dstg_t;

  typedef struct packed {
    logic           arith;
    logic           is_mul;
    logic           msign;
    logic           dz;
    logic [W-1:0]   iv;
    logic [W:0]     sr;
    logic [2*H-1:0] pp0;
    logic [L+H-1:0] pp1;
    logic [H+L-1:0] pp2;
    logic [2*L-1:0] pp3;
  } astg_t;

  typedef struct packed {
    logic          arith;
    logic          dz;
    logic          sign;
    logic [WW-1:0] mag;
    logic [W-1:0]  iv;
  } bstg_t;

  typedef struct packed {
    logic           is_real;
    logic           dz;
    logic           sign;
    logic [WW-1:0]  mag;
    logic [W-1:0]   iv;
    logic [LZW-1:0] lz;
  } cstg_t;

  typedef struct packed {
    logic          is_real;
    logic          dz;
    logic          sign;
    logic [WW-1:0] nrm;
    logic [10:0]   expo;
    logic [W-1:0]  iv;
  } estg_t;

  function automatic dstg_t div_step(input dstg_t s);
    dstg_t      r;
    logic [W:0] t;
    r = s;
    t = {s.rem, s.dv[W-1]};
    r.dv = s.dv << 1;
    if (t >= {1'b0, s.mb}) begin
      t = t - {1'b0, s.mb};
      r.q = {s.q[W-2:0], 1'b1};
    end else begin
      r.q = {s.q[W-2:0], 1'b0};
    end
    r.rem = t[W-1:0];
    return r;
  endfunction

  function automatic logic [LZW-1:0] lzc(input logic [WW-1:0] m);
    logic [LZW-1:0] z;
    z = '0;
    for (int i = 0; i < WW; i++) begin
      if (m[i]) begin
        z = LZW'(WW - 1 - i);
      end
    end
    return z;
  endfunction

  logic         adv;
  dstg_t        d0;
  dstg_t        d_r [W+1];
  logic [W:0]   dval_r;
  astg_t        a_nxt, a_r;
  bstg_t        b_nxt, b_r;
  cstg_t        c_nxt, c_r;
  estg_t        e_nxt, e_r;
  logic         a_v_r, b_v_r, c_v_r, e_v_r;
  out_t         out_nxt, out_r;
  logic         out_valid_r;
  dstg_t        dl;
  logic [W:0]   ae, be;
  logic [WW-1:0] mulm;
  logic [W:0]   srm;
  logic [XW-1:0] xv;
  logic [52:0]  mant;
  logic [53:0]  m54;
  logic         rnd_bit, sticky;
  logic [10:0]  expo_f;
  logic [51:0]  frac;

  // whole pipe moves when the output register is free or being taken
  assign adv       = !out_valid_r || out_ready;
  assign q_pop     = adv && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    d0.cmd = q_op.cmd;
    d0.dz  = q_op.dz;
    d0.a   = q_op.a[W-1:0];
    d0.sa  = q_op.a[W-1];
    d0.sb  = q_op.b[W-1];
    d0.ma  = d0.sa ? -q_op.a[W-1:0] : q_op.a[W-1:0];
    d0.mb  = d0.sb ? -q_op.b[W-1:0] : q_op.b[W-1:0];
    d0.dv  = d0.ma;
    d0.rem = '0;
    d0.q   = '0;
  end

  // operand prep, small results, partial products
  always_comb begin
    dl = d_r[W];
    ae = {dl.a[W-1], dl.a};
    a_nxt.msign  = dl.sa ^ dl.sb;
    a_nxt.dz     = dl.dz;
    a_nxt.is_mul = (dl.cmd == CMD_MUL);
    a_nxt.arith  = 1'b1;
    a_nxt.iv     = '0;
    a_nxt.sr     = '0;
    a_nxt.pp0 = dl.ma[H-1:0] * dl.mb[H-1:0];
    a_nxt.pp1 = dl.ma[W-1:H] * dl.mb[H-1:0];
    a_nxt.pp2 = dl.ma[H-1:0] * dl.mb[W-1:H];
    a_nxt.pp3 = dl.ma[W-1:H] * dl.mb[W-1:H];
    // second operand rebuilt from sign and magnitude
    be = {dl.sb, dl.sb ? -dl.mb : dl.mb};
    unique case (dl.cmd)
      CMD_ADD:  a_nxt.sr = ae + be;
      CMD_SUB:  a_nxt.sr = ae - be;
      CMD_MUL:  a_nxt.sr = '0;
      CMD_ABS:  a_nxt.sr = dl.sa ? -ae : ae;
      CMD_NEG:  a_nxt.sr = -ae;
      CMD_IDIV: begin
        a_nxt.arith = 1'b0;
        a_nxt.iv    = dl.dz ? '0 : (a_nxt.msign ? -dl.q : dl.q);
      end
      CMD_MOD:  begin
        a_nxt.arith = 1'b0;
        a_nxt.iv    = dl.dz ? '0 : (dl.sa ? -dl.rem : dl.rem);
      end
      CMD_PASS: begin
        a_nxt.arith = 1'b0;
        a_nxt.iv    = dl.a;
      end
      default:  a_nxt.arith = 1'b0;
    endcase
  end

  // exact result as sign and magnitude
  always_comb begin
    mulm = WW'(a_r.pp0) + (WW'(a_r.pp1) << H) + (WW'(a_r.pp2) << H)
         + (WW'(a_r.pp3) << (2 * H));
    srm  = a_r.sr[W] ? -a_r.sr : a_r.sr;
    b_nxt.arith = a_r.arith;
    b_nxt.dz    = a_r.dz;
    b_nxt.iv    = a_r.iv;
    if (a_r.is_mul) begin
      b_nxt.sign = a_r.msign;
      b_nxt.mag  = mulm;
    end else begin
      b_nxt.sign = a_r.sr[W];
      b_nxt.mag  = WW'(srm);
    end
  end

  // range check and leading zero count
  always_comb begin
    logic          fits;
    logic [WW-1:0] lim;
    lim  = WW'(1) << (W - 1);
    fits = b_r.sign ? (b_r.mag <= lim) : (b_r.mag < lim);
    c_nxt.is_real = b_r.arith && !fits;
    c_nxt.dz      = b_r.dz;
    c_nxt.sign    = b_r.sign;
    c_nxt.mag     = b_r.mag;
    c_nxt.lz      = lzc(b_r.mag);
    if (!b_r.arith) begin
      c_nxt.iv = b_r.iv;
    end else if (fits) begin
      c_nxt.iv = b_r.sign ? -b_r.mag[W-1:0] : b_r.mag[W-1:0];
    end else begin
      c_nxt.iv = '0;
    end
  end

  // normalize
  always_comb begin
    e_nxt.is_real = c_r.is_real;
    e_nxt.dz      = c_r.dz;
    e_nxt.sign    = c_r.sign;
    e_nxt.iv      = c_r.iv;
    e_nxt.nrm     = c_r.mag << c_r.lz;
    e_nxt.expo    = 11'(WW - 1 + 1023) - 11'(c_r.lz);
  end

  // round to nearest even and pack
  always_comb begin
    xv      = {e_r.nrm, 55'd0};
    mant    = xv[XW-1 -: 53];
    rnd_bit = xv[WW+1];
    sticky  = |xv[WW:0];
    m54     = {1'b0, mant} + 54'(rnd_bit && (sticky || mant[0]));
    if (m54[53]) begin
      frac   = m54[52:1];
      expo_f = e_r.expo + 11'd1;
    end else begin
      frac   = m54[51:0];
      expo_f = e_r.expo;
    end
    out_nxt.int_value = 32'(e_r.iv);
    out_nxt.real_bits = e_r.is_real ? {e_r.sign, expo_f, frac} : 64'd0;
    out_nxt.is_real   = e_r.is_real;
    out_nxt.div_zero  = e_r.dz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dval_r      <= '0;
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      e_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      dval_r      <= {dval_r[W-1:0], q_valid};
      a_v_r       <= dval_r[W];
      b_v_r       <= a_v_r;
      c_v_r       <= b_v_r;
      e_v_r       <= c_v_r;
      out_valid_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r[0] <= d0;
      for (int k = 0; k < W; k++) begin
        d_r[k+1] <= div_step(d_r[k]);
      end
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      c_r   <= c_nxt;
      e_r   <= e_nxt;
      out_r <= out_nxt;
    end
  end

`ifndef SYNTHESIS
  a_real_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.is_real) |-> (out_r.int_value == 32'd0 && !out_r.div_zero))
    else $error("promoted result carries integer or error bits");
  a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.div_zero) |-> (out_r.real_bits == 64'd0 && out_r.int_value == 32'd0))
    else $error("zero divisor result not cleared");
  a_real_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.is_real) |-> (out_r.real_bits[62:52] >= 11'(1023 + W - 1)))
    else $error("promoted value below integer range");
`endif

endmodule

`default_nettype wire

// ===== design/integer_alu_overflow_promote.sv =====
// throughput: one item per cycle unless out_ready stalls the pipe; the divider is pipelined
//   in DATA_WIDTH stages and a two-entry queue sits between the front and the execution pipe
// reset: rst_n synchronous, active low; clears queue and stage valid bits only
`default_nettype none

module integer_alu_overflow_promote
  import iaop_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  logic q_full;
  logic q_push;
  op_t  q_op_in;
  logic q_pop;
  logic q_valid;
  op_t  q_head;

  iaop_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_op     (q_op_in)
  );

  iaop_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (q_op_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_op    (q_head)
  );

  iaop_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_op      (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
